### sv/assert_macros.svh
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, suppressed while reset is asserted (active low)
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/psfp_pkg.sv
// shared constants and types for the particle sensor frame parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psfp_pkg;

    // frame layout
    localparam logic [7:0]  SyncFirst   = 8'h42;
    localparam logic [7:0]  SyncSecond  = 8'h4D;
    localparam logic [15:0] ExpectedLen = 16'd20;
    localparam logic [4:0]  SummedBytes = 5'd22;
    localparam logic [4:0]  LengthPos   = 5'd3;
    localparam logic [4:0]  FirstRdPos  = 5'd5;
    localparam logic [4:0]  LastRdPos   = 5'd15;
    localparam logic [4:0]  LastPos     = 5'd23;
    localparam int          NumReadings = 6;

    // result status codes
    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusBadStart = 2'd1;
    localparam logic [1:0] StatusBadLen   = 2'd2;
    localparam logic [1:0] StatusBadSum   = 2'd3;

    typedef logic [15:0] word_t;

    typedef struct packed {
        logic [1:0] status;
        word_t      pm1_indoor;
        word_t      pm2_5_indoor;
        word_t      pm10_indoor;
        word_t      pm1_outdoor;
        word_t      pm2_5_outdoor;
        word_t      pm10_outdoor;
    } result_t;

endpackage

`default_nettype wire

### sv/psfp_frame_core.sv
// frame state and per-byte decode: position, checksum, length and readings
// depends on psfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module psfp_frame_core
    import psfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    output result_t         res
);

    logic [4:0]  pos_reg, pos_next, pos;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  latch_reg, latch_next;
    logic [15:0] len_reg, len_next;
    word_t       rd_reg [NumReadings];
    logic        rd_we;
    logic [4:0]  rd_off;
    logic [2:0]  rd_idx;
    logic [15:0] sum_add, word;
    logic        emit_bad_start, emit_final;

    // out-of-range position is taken as frame start
    assign pos     = (pos_reg > LastPos) ? 5'd0 : pos_reg;
    assign sum_add = sum_reg + {8'd0, rx_byte};
    assign word    = {latch_reg, rx_byte};
    assign rd_off  = pos - FirstRdPos;
    assign rd_idx  = rd_off[3:1];

    // next-state decode for one byte
    always_comb begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        latch_next     = latch_reg;
        len_next       = len_reg;
        rd_we          = 1'b0;
        emit_bad_start = 1'b0;
        emit_final     = 1'b0;
        if (advance) begin
            if (pos == 5'd0) begin
                if (rx_byte != SyncFirst) begin
                    emit_bad_start = 1'b1;
                    pos_next       = 5'd0;
                end else begin
                    sum_next = {8'd0, rx_byte};
                    pos_next = 5'd1;
                end
            end else if (pos == 5'd1) begin
                if (rx_byte != SyncSecond) begin
                    emit_bad_start = 1'b1;
                    pos_next       = 5'd0;
                end else begin
                    sum_next = sum_add;
                    pos_next = 5'd2;
                end
            end else begin
                if (pos < SummedBytes) begin
                    sum_next = sum_add;
                end
                if (!pos[0]) begin
                    latch_next = rx_byte;
                    pos_next   = pos + 5'd1;
                end else if (pos == LengthPos) begin
                    len_next = word;
                    pos_next = pos + 5'd1;
                end else if (pos <= LastRdPos) begin
                    rd_we    = 1'b1;
                    pos_next = pos + 5'd1;
                end else if (pos == LastPos) begin
                    emit_final = 1'b1;
                    pos_next   = 5'd0;
                end else begin
                    pos_next = pos + 5'd1;
                end
            end
        end
    end

    // result build: readings only for ok or bad checksum
    always_comb begin
        res        = '0;
        res_valid  = emit_bad_start | emit_final;
        if (emit_bad_start) begin
            res.status = StatusBadStart;
        end else if (len_reg != ExpectedLen) begin
            res.status = StatusBadLen;
        end else begin
            res.status        = (word != sum_reg) ? StatusBadSum : StatusOk;
            res.pm1_indoor    = rd_reg[0];
            res.pm2_5_indoor  = rd_reg[1];
            res.pm10_indoor   = rd_reg[2];
            res.pm1_outdoor   = rd_reg[3];
            res.pm2_5_outdoor = rd_reg[4];
            res.pm10_outdoor  = rd_reg[5];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 5'd0;
            sum_reg   <= 16'd0;
            latch_reg <= 8'd0;
            len_reg   <= 16'd0;
        end else begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            latch_reg <= latch_next;
            len_reg   <= len_next;
        end
    end

    // reading words, each written at its own frame position
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NumReadings; k++) begin
            if (rd_we && (rd_idx == 3'(k))) begin
                rd_reg[k] <= word;
            end
        end
    end

endmodule

`default_nettype wire

### sv/psfp_out_reg.sv
// result output register on the m_ side
// depends on psfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module psfp_out_reg
    import psfp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    m_ready,
    output logic         m_valid,
    output result_t      m_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // hold until transfer, reload when a new result arrives
    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

### sv/particle_sensor_frame_parser_unit.sv
// top level of the particle sensor frame parser
// depends on psfp_pkg, psfp_frame_core, psfp_out_reg
`timescale 1ns / 1ps
`default_nettype none

// Parses a 24-byte particle sensor frame (0x42 0x4D, length 20, six
// big-endian readings, 16-bit checksum over bytes 0-21) one byte per transfer.
// A result comes out after byte 23, or at once on a bad start byte; other
// bytes give no result. Throughput is one byte per cycle while no result is
// stalled in the output register. Each byte passes an input register and then
// the frame-state update, which loads the result into the output register.
// While a result waits in the output register, the byte held in the input
// register waits too, so the input stalls one byte after the result.
module particle_sensor_frame_parser_unit
    import psfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_pm1_indoor,
    output logic [15:0]      m_pm2_5_indoor,
    output logic [15:0]      m_pm10_indoor,
    output logic [15:0]      m_pm1_outdoor,
    output logic [15:0]      m_pm2_5_outdoor,
    output logic [15:0]      m_pm10_outdoor
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       consume;
    logic       res_valid;
    result_t    res;
    result_t    m_data;

    // a byte moves on when the output register can take any result it makes
    assign consume = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || consume;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    psfp_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (consume),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    psfp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    assign m_status        = m_data.status;
    assign m_pm1_indoor    = m_data.pm1_indoor;
    assign m_pm2_5_indoor  = m_data.pm2_5_indoor;
    assign m_pm10_indoor   = m_data.pm10_indoor;
    assign m_pm1_outdoor   = m_data.pm1_outdoor;
    assign m_pm2_5_outdoor = m_data.pm2_5_outdoor;
    assign m_pm10_outdoor  = m_data.pm10_outdoor;

endmodule

`default_nettype wire

### sv/psfp_checker.sv
// port-level checks for the particle sensor frame parser, bound to the top
// depends on psfp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module psfp_checker
    import psfp_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [15:0] m_pm1_indoor,
    input wire logic [15:0] m_pm2_5_indoor,
    input wire logic [15:0] m_pm10_indoor,
    input wire logic [15:0] m_pm1_outdoor,
    input wire logic [15:0] m_pm2_5_outdoor,
    input wire logic [15:0] m_pm10_outdoor
);

    logic        readings_zero;
    logic        no_readings;
    logic [95:0] readings_all;

    assign readings_zero = (m_pm1_indoor == 16'd0) && (m_pm2_5_indoor == 16'd0)
                        && (m_pm10_indoor == 16'd0) && (m_pm1_outdoor == 16'd0)
                        && (m_pm2_5_outdoor == 16'd0) && (m_pm10_outdoor == 16'd0);
    assign no_readings   = (m_status == StatusBadStart) || (m_status == StatusBadLen);
    assign readings_all  = {m_pm1_indoor, m_pm2_5_indoor, m_pm10_indoor,
                            m_pm1_outdoor, m_pm2_5_outdoor, m_pm10_outdoor};

    // stalled result holds its status
    `ASSERT_RST(a_hold_status, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status), "result changed while stalled")

    // bad start and bad length carry no readings
    `ASSERT_RST(a_err_zero, aclk, aresetn, m_valid && no_readings |-> readings_zero, "readings on an error result")

    // no result right after reset
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // stalled result holds its readings
    `ASSERT_RST(a_hold_data, aclk, aresetn, m_valid && !m_ready |=> $stable(readings_all), "readings changed while stalled")

endmodule

bind particle_sensor_frame_parser_unit psfp_checker u_psfp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_pm1_indoor    (m_pm1_indoor),
    .m_pm2_5_indoor  (m_pm2_5_indoor),
    .m_pm10_indoor   (m_pm10_indoor),
    .m_pm1_outdoor   (m_pm1_outdoor),
    .m_pm2_5_outdoor (m_pm2_5_outdoor),
    .m_pm10_outdoor  (m_pm10_outdoor)
);

`default_nettype wire

### tb/tb.sv
// self-checking testbench for particle_sensor_frame_parser_unit
// depends on psfp_pkg and the parser top level; predicts every result in-line
`timescale 1ns / 1ps

module tb;
    import psfp_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int DrainCycles = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_pm1_indoor;
    logic [15:0] m_pm2_5_indoor;
    logic [15:0] m_pm10_indoor;
    logic [15:0] m_pm1_outdoor;
    logic [15:0] m_pm2_5_outdoor;
    logic [15:0] m_pm10_outdoor;

    // idle rates in percent and the long receiver hold-off
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // expected results and the predicted parser state
    result_t     expected_frames[$];
    logic [4:0]  frame_pos = '0;
    word_t       frame_sum = '0;
    logic [7:0]  hi_byte = '0;
    word_t       len_word = '0;
    word_t       readings_model [NumReadings];

    particle_sensor_frame_parser_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_pm1_indoor    (m_pm1_indoor),
        .m_pm2_5_indoor  (m_pm2_5_indoor),
        .m_pm10_indoor   (m_pm10_indoor),
        .m_pm1_outdoor   (m_pm1_outdoor),
        .m_pm2_5_outdoor (m_pm2_5_outdoor),
        .m_pm10_outdoor  (m_pm10_outdoor)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // frame state update for one accepted byte
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [4:0] pos;
        logic [4:0] rd_off;
        word_t      word;
        result_t    res;
        pos = (frame_pos > LastPos) ? 5'd0 : frame_pos;
        res = '0;
        if (pos == 5'd0) begin
            if (b != SyncFirst) begin
                frame_pos = 5'd0;
                res.status = StatusBadStart;
                expected_frames.push_back(res);
            end else begin
                frame_sum = {8'h00, b};
                frame_pos = 5'd1;
            end
        end else if (pos == 5'd1) begin
            if (b != SyncSecond) begin
                frame_pos = 5'd0;
                res.status = StatusBadStart;
                expected_frames.push_back(res);
            end else begin
                frame_sum = frame_sum + b;
                frame_pos = 5'd2;
            end
        end else begin
            if (pos < SummedBytes) frame_sum = frame_sum + b;
            if (!pos[0]) begin
                hi_byte = b;
                frame_pos = pos + 5'd1;
            end else begin
                word = {hi_byte, b};
                if (pos == LengthPos) begin
                    len_word = word;
                end else if (pos <= LastRdPos) begin
                    rd_off = pos - FirstRdPos;
                    readings_model[rd_off[3:1]] = word;
                end
                if (pos == LastPos) begin
                    // length error wins over checksum error and hides readings
                    frame_pos = 5'd0;
                    if (len_word != ExpectedLen) begin
                        res.status = StatusBadLen;
                    end else begin
                        res.status        = (word != frame_sum) ? StatusBadSum : StatusOk;
                        res.pm1_indoor    = readings_model[0];
                        res.pm2_5_indoor  = readings_model[1];
                        res.pm10_indoor   = readings_model[2];
                        res.pm1_outdoor   = readings_model[3];
                        res.pm2_5_outdoor = readings_model[4];
                        res.pm10_outdoor  = readings_model[5];
                    end
                    expected_frames.push_back(res);
                end else begin
                    frame_pos = pos + 5'd1;
                end
            end
        end
    endtask

    // one byte transfer, then an optional idle gap
    task automatic send_byte(input logic [7:0] b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parse_rx_byte(b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // full 24-byte frame; sum_flip nonzero corrupts the checksum
    task automatic send_frame(input word_t len, input logic [95:0] rd,
                              input logic [47:0] pad, input word_t sum_flip);
        logic [7:0] frame_buf [0:23];
        word_t      sum;
        int         k;
        frame_buf[0] = SyncFirst;
        frame_buf[1] = SyncSecond;
        frame_buf[2] = len[15:8];
        frame_buf[3] = len[7:0];
        for (k = 0; k < 12; k++) frame_buf[4 + k] = rd[95 - 8 * k -: 8];
        for (k = 0; k < 6; k++) frame_buf[16 + k] = pad[47 - 8 * k -: 8];
        sum = '0;
        for (k = 0; k < 22; k++) sum = sum + frame_buf[k];
        sum = sum ^ sum_flip;
        frame_buf[22] = sum[15:8];
        frame_buf[23] = sum[7:0];
        for (k = 0; k < 24; k++) send_byte(frame_buf[k]);
    endtask

    // random byte that is not the given sync value
    function automatic logic [7:0] rand_byte_except(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == avoid) b = ~b;
        return b;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // receiver: random stalls plus the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $error("unexpected result transfer, status %0d", m_status);
                fail_count++;
            end else begin
                exp_res = expected_frames.pop_front();
                check_field("status", {14'd0, exp_res.status}, {14'd0, m_status});
                check_field("pm1_indoor", exp_res.pm1_indoor, m_pm1_indoor);
                check_field("pm2_5_indoor", exp_res.pm2_5_indoor, m_pm2_5_indoor);
                check_field("pm10_indoor", exp_res.pm10_indoor, m_pm10_indoor);
                check_field("pm1_outdoor", exp_res.pm1_outdoor, m_pm1_outdoor);
                check_field("pm2_5_outdoor", exp_res.pm2_5_outdoor, m_pm2_5_outdoor);
                check_field("pm10_outdoor", exp_res.pm10_outdoor, m_pm10_outdoor);
            end
        end
    end

    // extremes, every status and resync after bad start bytes
    task automatic test_directed_frames();
        send_frame(ExpectedLen, '0, '0, '0);
        send_frame(ExpectedLen, {96{1'b1}}, {48{1'b1}}, '0);
        send_frame(ExpectedLen, 96'h0001_8000_7fff_00ff_ff00_1234, 48'h0102_0304_0506, '0);
        send_frame(ExpectedLen, 96'h1111_2222_3333_4444_5555_6666, '0, 16'h0001);
        send_frame(ExpectedLen, {96{1'b1}}, '0, 16'hffff);
        send_frame(16'h0000, 96'habcd_ef01_2345_6789_abcd_ef01, '0, '0);
        send_frame(16'hffff, {96{1'b1}}, {48{1'b1}}, 16'h8000);
        send_frame(16'h0015, 96'h0001_0002_0003_0004_0005_0006, '0, '0);
        send_frame(16'h1400, 96'h0001_0002_0003_0004_0005_0006, '0, '0);
        // bad first byte, bad second byte, and a repeated first sync
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(SyncSecond);
        send_byte(SyncFirst);
        send_byte(8'h00);
        send_byte(SyncFirst);
        send_byte(SyncFirst);
        send_byte(SyncFirst);
        send_byte(8'hff);
        send_frame(ExpectedLen, 96'h0fed_cba9_8765_4321_0fed_cba9, '0, '0);
    endtask

    // mostly well-formed frames, some broken ones and noise
    task automatic test_random_stream(input int n_bytes);
        int    sent;
        int    kind;
        int    k;
        int    n_noise;
        word_t len;
        word_t flip;
        sent = 0;
        while (sent < n_bytes) begin
            kind = $urandom_range(99);
            if (kind < 68) begin
                send_frame(ExpectedLen, {$urandom, $urandom, $urandom},
                           {$urandom, 16'($urandom)}, '0);
                sent += 24;
            end else if (kind < 78) begin
                flip = 16'($urandom_range(1, 65535));
                send_frame(ExpectedLen, {$urandom, $urandom, $urandom},
                           {$urandom, 16'($urandom)}, flip);
                sent += 24;
            end else if (kind < 86) begin
                len = 16'($urandom_range(65535));
                if (len == ExpectedLen) len = ~len;
                flip = ($urandom_range(1) == 0) ? 16'h0000 : 16'($urandom);
                send_frame(len, {$urandom, $urandom, $urandom},
                           {$urandom, 16'($urandom)}, flip);
                sent += 24;
            end else if (kind < 91) begin
                send_byte(SyncFirst);
                send_byte(rand_byte_except(SyncSecond));
                sent += 2;
            end else begin
                n_noise = $urandom_range(1, 6);
                for (k = 0; k < n_noise; k++) send_byte(8'($urandom));
                sent += n_noise;
            end
        end
    endtask

    // long receiver hold-off while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        int k;
        hold_off_cycles = 250;
        for (k = 0; k < 12; k++) send_byte(rand_byte_except(SyncFirst));
        for (k = 0; k < 3; k++) begin
            send_frame(ExpectedLen, {$urandom, $urandom, $urandom},
                       {$urandom, 16'($urandom)}, '0);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 27;
        recv_idle_pct = 66;
        test_directed_frames();
        test_random_stream(200);

        send_idle_pct = 66;
        recv_idle_pct = 27;
        test_random_stream(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_stream(200);

        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
